@@ rtl/core/ats_pkg.sv @@
// Shared types and constants for the animation track scheduler.
// No dependencies; imported by ats_div and animation_track_scheduler.
`default_nettype none

package ats_pkg;

	localparam int TIME_W = 31;
	localparam int STAMP_W = 32;
	localparam int ALPHA_W = 17;
	localparam int FRAC_W = 16;
	localparam int IDX_W = 4;
	localparam int KIND_W = 2;
	localparam int DIV_CNT_W = 4;

	localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_START  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd3;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

	typedef struct packed {
		logic                is_callback;
		logic [IDX_W-1:0]    track_index;
		logic [ALPHA_W-1:0]  alpha;
		logic                running;
		logic                accepted;
		logic                last;
	} res_t;

	typedef struct packed {
		logic                start;
		logic [TIME_W-1:0]   rem;
		logic [TIME_W-1:0]   den;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [FRAC_W-1:0]   quo;
	} div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/ats_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ats_ram #(
	parameter int WIDTH = 62,
	parameter int DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/ats_div.sv @@
// Restoring divider, one quotient bit per cycle, for track progress fractions.
// Depends on ats_pkg (div_req_t, div_rsp_t, widths).
`default_nettype none

module ats_div
	import ats_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TIME_W-1:0]    rem_q;
	logic [TIME_W-1:0]    den_q;
	logic [FRAC_W-1:0]    quo_q;
	logic [TIME_W:0]      shifted;
	logic                 fits;

	assign shifted = {rem_q, 1'b0};
	assign fits = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(FRAC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem;
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? TIME_W'(shifted - {1'b0, den_q}) : shifted[TIME_W-1:0];
			quo_q <= {quo_q[FRAC_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

`default_nettype wire

@@ rtl/core/animation_track_scheduler.sv @@
// Animation track scheduler top level: sequencer, track table RAM, output register.
// Depends on ats_pkg, ats_ram and ats_div.
//
//  channel  signals                                     flow  accepted when
//  in       in_valid in_stall kind track_start          in    in_valid & !in_stall
//           track_end now_ms
//  out      out_valid out_stall is_callback track_index out   out_valid & !out_stall
//           alpha running accepted last
//  cfg      cfg_we cfg_wdata (duration_ms)              in    cfg_we
//
// Add, start and refused or idle items go from decode to the status beat, then to idle.
// Update: each track takes a table RAM read and check, plus the divider and
// one output beat for an active track; reaching the duration adds a stop.
// Stop emits one beat per track per cycle while out_stall is low, then the status beat.
// No clearing pass after reset; out_stall holds the sequencer at its next beat.
`default_nettype none

module animation_track_scheduler
	import ats_pkg::*;
#(
	parameter int MAX_TRACKS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [TIME_W-1:0]   cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [KIND_W-1:0]   kind,
	input  wire logic [TIME_W-1:0]   track_start,
	input  wire logic [TIME_W-1:0]   track_end,
	input  wire logic [STAMP_W-1:0]  now_ms,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     is_callback,
	output logic [IDX_W-1:0]         track_index,
	output logic [ALPHA_W-1:0]       alpha,
	output logic                     running,
	output logic                     accepted,
	output logic                     last
);

	localparam int CW = $clog2(MAX_TRACKS + 1);
	localparam int IW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_RD     = 3'd2;
	localparam logic [2:0] ST_EVAL   = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;
	localparam logic [2:0] ST_HALT   = 3'd6;
	localparam logic [2:0] ST_STATUS = 3'd7;

	logic [2:0]            state_q;
	logic [KIND_W-1:0]     kind_q;
	logic [TIME_W-1:0]     ts_q;
	logic [TIME_W-1:0]     te_q;
	logic [STAMP_W-1:0]    now_q;
	logic [TIME_W-1:0]     duration_q;
	logic [CW-1:0]         count_q;
	logic                  running_q;
	logic [STAMP_W-1:0]    stamp_q;
	logic [MAX_TRACKS-1:0] done_q;
	logic [TIME_W-1:0]     t_q;
	logic [CW-1:0]         pos_q;
	logic                  acc_q;
	logic                  out_valid_q;
	res_t                  out_q;

	logic [2*TIME_W-1:0]   ram_rdata;
	logic [TIME_W-1:0]     trk_b;
	logic [TIME_W-1:0]     trk_e;
	logic [STAMP_W-1:0]    diff;
	logic [TIME_W-1:0]     t_calc;
	logic [CW-1:0]         pos_nxt;
	logic                  last_trk;
	logic                  is_active;
	logic                  is_ended;
	logic                  out_free;
	logic                  emit;
	res_t                  res;
	logic                  step_done;
	logic                  add_ok;
	div_req_t              div_req;
	div_rsp_t              div_rsp;

	assign in_stall = state_q != ST_IDLE;
	assign out_free = !out_valid_q || !out_stall;

	assign trk_b = ram_rdata[2*TIME_W-1:TIME_W];
	assign trk_e = ram_rdata[TIME_W-1:0];

	assign diff   = now_q - stamp_q;
	assign t_calc = (diff > {1'b0, duration_q}) ? duration_q : diff[TIME_W-1:0];

	assign pos_nxt   = pos_q + 1'b1;
	assign last_trk  = pos_nxt == count_q;
	assign is_active = (trk_b <= t_q) && (trk_e > t_q);
	assign is_ended  = (trk_e <= t_q) && !done_q[pos_q[IW-1:0]];
	assign add_ok    = (state_q == ST_DECODE) && (kind_q == KIND_ADD)
		&& (count_q < CW'(MAX_TRACKS));

	assign step_done = ((state_q == ST_EVAL) && !is_active && (!is_ended || out_free))
		|| ((state_q == ST_EMIT) && out_free);

	assign div_req.start = (state_q == ST_EVAL) && is_active;
	assign div_req.rem   = t_q - trk_b;
	assign div_req.den   = trk_e - trk_b;

	ats_ram #(
		.WIDTH (2 * TIME_W),
		.DEPTH (MAX_TRACKS)
	) u_track_ram (
		.clk   (clk),
		.we    (add_ok),
		.waddr (count_q[IW-1:0]),
		.wdata ({ts_q, te_q}),
		.re    (state_q == ST_RD),
		.raddr (pos_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	ats_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		emit = 1'b0;
		res  = '0;
		res.track_index = IDX_W'(pos_q);
		unique case (state_q)
			ST_EVAL: begin
				if (!is_active && is_ended) begin
					emit            = 1'b1;
					res.is_callback = 1'b1;
					res.alpha       = ALPHA_ONE;
					res.running     = 1'b1;
				end
			end
			ST_EMIT: begin
				emit            = 1'b1;
				res.is_callback = 1'b1;
				res.alpha       = {1'b0, div_rsp.quo};
				res.running     = 1'b1;
			end
			ST_HALT: begin
				if (pos_q != count_q) begin
					emit            = 1'b1;
					res.is_callback = 1'b1;
				end
			end
			ST_STATUS: begin
				emit            = 1'b1;
				res.track_index = '0;
				res.running     = running_q;
				res.accepted    = acc_q;
				res.last        = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			kind_q <= kind;
			ts_q   <= track_start;
			te_q   <= track_end;
			now_q  <= now_ms;
		end
		if (state_q == ST_DECODE) begin
			t_q <= t_calc;
		end
		if (emit && out_free) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			duration_q  <= '0;
			count_q     <= '0;
			running_q   <= 1'b0;
			stamp_q     <= '0;
			done_q      <= '0;
			pos_q       <= '0;
			acc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				duration_q <= cfg_wdata;
			end

			if (emit && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					acc_q   <= 1'b0;
					pos_q   <= '0;
					state_q <= ST_STATUS;
					unique case (kind_q)
						KIND_ADD: begin
							if (add_ok) begin
								done_q[count_q[IW-1:0]] <= 1'b0;
								count_q <= count_q + 1'b1;
								acc_q   <= 1'b1;
							end
						end
						KIND_START: begin
							if (!running_q) begin
								stamp_q   <= now_q;
								running_q <= 1'b1;
								acc_q     <= 1'b1;
							end
						end
						KIND_STOP: begin
							if (running_q) begin
								running_q <= 1'b0;
								done_q    <= '0;
								acc_q     <= 1'b1;
								state_q   <= ST_HALT;
							end
						end
						KIND_UPDATE: begin
							if (running_q) begin
								acc_q <= 1'b1;
								if (count_q != '0) begin
									state_q <= ST_RD;
								end else if (t_calc == duration_q) begin
									running_q <= 1'b0;
									done_q    <= '0;
									state_q   <= ST_HALT;
								end
							end
						end
						default: begin
							state_q <= ST_STATUS;
						end
					endcase
				end
				ST_RD: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (is_active) begin
						state_q <= ST_DIV;
					end else if (is_ended && out_free) begin
						done_q[pos_q[IW-1:0]] <= 1'b1;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					state_q <= ST_EMIT;
				end
				ST_HALT: begin
					if (pos_q == count_q) begin
						state_q <= ST_STATUS;
					end else if (out_free) begin
						pos_q <= pos_nxt;
					end
				end
				ST_STATUS: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// advance to the next track; after the last, stop if the duration is reached, else report status
			if (step_done) begin
				if (last_trk) begin
					if (t_q == duration_q) begin
						running_q <= 1'b0;
						done_q    <= '0;
						pos_q     <= '0;
						state_q   <= ST_HALT;
					end else begin
						state_q <= ST_STATUS;
					end
				end else begin
					pos_q   <= pos_nxt;
					state_q <= ST_RD;
				end
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign is_callback = out_q.is_callback;
	assign track_index = out_q.track_index;
	assign alpha       = out_q.alpha;
	assign running     = out_q.running;
	assign accepted    = out_q.accepted;
	assign last        = out_q.last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_TRACKS))
		else $error("track count above table size");

	a_div_only_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_EMIT) |-> running_q)
		else $error("divide outside a running update");

	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_EVAL || state_q == ST_DIV || state_q == ST_EMIT)
		|-> (pos_q < count_q))
		else $error("track scan past the track count");

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_DECODE))
		else $error("accepted beat not decoded");

	a_halt_not_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HALT) |-> !running_q)
		else $error("stop sweep with running flag set");

endmodule

`default_nettype wire
